// ===== hdl/sipi_pkg.sv =====
`default_nettype none

package sipi_pkg;

	// Table and arithmetic sizing
	localparam int MAX_POINTS    = 16;
	localparam int FRACTION_BITS = 30;
	localparam int IDX_W         = $clog2(MAX_POINTS);
	localparam int CNT_W         = $clog2(MAX_POINTS + 1);

	// Queue depths between and after the two halves
	localparam int CMDQ_DEPTH = 2;
	localparam int OUTQ_DEPTH = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_START_TIME  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVING     = 2'd2;

	// Item mode codes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EVAL  = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [3:0]         point_index;
		logic [31:0]        point_offset;
		logic signed [31:0] point_temp;
		logic [31:0]        now_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] setpoint;
		logic               past_end;
	} out_item_t;

	// Configuration as seen by the front end
	typedef struct packed {
		logic [31:0]      start_time;
		logic [CNT_W-1:0] count;
		logic             driving;
	} cfg_t;

	// Command from front to back: value is the point offset for a write,
	// the elapsed time for an evaluate
	typedef struct packed {
		logic               is_eval;
		logic [IDX_W-1:0]   idx;
		logic [31:0]        value;
		logic signed [31:0] temp;
		logic [CNT_W-1:0]   count;
	} cmd_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic [FRACTION_BITS-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/setpoint_profile_interpolator_core.sv =====
// Channel   Direction  Handshake          Payload
// item      in         push / full        in_item_t (mode, point_index, offset, temp, now)
// result    out        pop / empty        out_item_t (setpoint, past_end)
// config    in         wr_en, wr_index    wr_data, 32 bits
//
// A point write goes from the command queue straight into the table. An evaluate
// reads and compares each table point scanned, then, when the elapsed time lies
// between two points, interpolates through the bit-serial divider and a split multiply.
// Reset clears control state only; table entries are undefined until written.
// A two-entry command queue and a two-entry result queue let input and output
// stall independently of the sequencer.
`default_nettype none

module setpoint_profile_interpolator_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  push,
	output logic                                 full,
	input  sipi_pkg::in_item_t                   item,
	output logic                                 empty,
	input  wire                                  pop,
	output sipi_pkg::out_item_t                  result,
	input  wire                                  wr_en,
	input  wire [sipi_pkg::CFG_IDX_W-1:0]        wr_index,
	input  wire [sipi_pkg::CFG_DATA_W-1:0]       wr_data
);
	import sipi_pkg::*;

	logic [31:0] start_time_q;
	logic [4:0]  point_count_q;
	logic        driving_q;
	cfg_t        cfg;
	logic        cmd_valid;
	logic        cmd_pop;
	cmd_t        cmd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q  <= '0;
			point_count_q <= '0;
			driving_q     <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_TIME:  start_time_q  <= wr_data[31:0];
				REG_POINT_COUNT: point_count_q <= wr_data[4:0];
				REG_DRIVING:     driving_q     <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// Effective count saturates at the table size
	assign cfg.start_time = start_time_q;
	assign cfg.driving    = driving_q;
	assign cfg.count      = (int'(point_count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
		: CNT_W'(point_count_q);

	sipi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	sipi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== hdl/sipi_front.sv =====
`default_nettype none

module sipi_front (
	input  wire                clk,
	input  wire                arst_n,
	input  sipi_pkg::cfg_t     cfg,
	input  wire                push,
	output logic               full,
	input  sipi_pkg::in_item_t item,
	output logic               cmd_valid,
	output sipi_pkg::cmd_t     cmd,
	input  wire                cmd_pop
);
	import sipi_pkg::*;

	localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

	cmd_t            q_mem [CMDQ_DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [AW:0]     cnt_q;
	logic            keep;
	logic            enq;
	logic            deq;
	cmd_t            cmd_d;

	// Classify: drop writes beyond the table and evaluates that cannot give a result
	always_comb begin
		cmd_d.is_eval = item.mode;
		cmd_d.idx     = IDX_W'(item.point_index);
		cmd_d.temp    = item.point_temp;
		cmd_d.count   = cfg.count;
		if (item.mode == MODE_WRITE) begin
			cmd_d.value = item.point_offset;
			keep        = int'(item.point_index) < MAX_POINTS;
		end else begin
			cmd_d.value = item.now_time - cfg.start_time;
			keep        = cfg.driving && (cfg.count != '0) && (item.now_time != '0)
				&& (cfg.start_time <= item.now_time);
		end
	end

	assign full      = (cnt_q == (AW + 1)'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rd_ptr_q];
	assign enq       = push && !full && keep;
	assign deq       = cmd_pop && cmd_valid;

	// Command queue storage
	always_ff @(posedge clk) begin
		if (enq) begin
			q_mem[wr_ptr_q] <= cmd_d;
		end
	end

	// Command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({enq, deq})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sipi_divider.sv =====
`default_nettype none

module sipi_divider (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sipi_pkg::div_req_t  req,
	output sipi_pkg::div_rsp_t  rsp
);
	import sipi_pkg::*;

	localparam int DCNT_W = $clog2(FRACTION_BITS + 1);

	logic [31:0]              rem_q;
	logic [31:0]              den_q;
	logic [FRACTION_BITS-1:0] quo_q;
	logic [DCNT_W-1:0]        cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [32:0]              rem_sh;
	logic [32:0]              rem_sub;
	logic                     ge;

	// One restoring step per cycle; the dividend is below the divisor,
	// so the quotient has only fraction bits
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = (rem_sh >= {1'b0, den_q});

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[FRACTION_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(FRACTION_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sipi_back.sv =====
`default_nettype none

module sipi_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	input  sipi_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  wire                 pop,
	output sipi_pkg::out_item_t result
);
	import sipi_pkg::*;

	localparam int AW        = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
	localparam int FRAC_LO_W = FRACTION_BITS / 2;
	localparam int FRAC_HI_W = FRACTION_BITS - FRAC_LO_W;
	localparam int PP_LO_W   = 34 + FRAC_LO_W;
	localparam int PP_HI_W   = 34 + FRAC_HI_W;
	localparam int ACC_W     = 34 + FRACTION_BITS;

	// Sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_READ   = 4'd1;
	localparam logic [3:0] S_CMP    = 4'd2;
	localparam logic [3:0] S_DIV    = 4'd3;
	localparam logic [3:0] S_MUL_LO = 4'd4;
	localparam logic [3:0] S_MUL_HI = 4'd5;
	localparam logic [3:0] S_ACC    = 4'd6;
	localparam logic [3:0] S_FIN    = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0]               state_q;
	logic [IDX_W-1:0]         addr_q;
	logic [CNT_W-1:0]         n_q;
	logic [31:0]              elapsed_q;
	logic [31:0]              prev_off_q;
	logic signed [31:0]       prev_tmp_q;
	logic signed [32:0]       diff_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic signed [PP_LO_W-1:0] pp_lo_q;
	logic signed [PP_HI_W-1:0] pp_hi_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [31:0]       res_q;
	logic                     past_q;

	// Point table
	logic [31:0]              off_mem [MAX_POINTS];
	logic signed [31:0]       tmp_mem [MAX_POINTS];
	logic [31:0]              rd_off_q;
	logic signed [31:0]       rd_tmp_q;
	logic                     tbl_we;

	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	logic                     gt;
	logic                     at_first;
	logic                     at_last;
	logic signed [PP_LO_W-1:0] pp_lo_d;
	logic signed [PP_HI_W-1:0] pp_hi_d;
	logic signed [ACC_W-1:0]  acc_d;
	logic signed [ACC_W-1:0]  interp_d;

	// Result queue
	out_item_t                oq_mem [OUTQ_DEPTH];
	logic [AW-1:0]            oq_wr_q, oq_rd_q;
	logic [AW:0]              oq_cnt_q;
	logic                     oq_full;
	logic                     oq_push;
	logic                     oq_pop;

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign tbl_we  = cmd_pop && !cmd.is_eval;

	// Table write and registered read at the scan address
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			off_mem[cmd.idx] <= cmd.value;
			tmp_mem[cmd.idx] <= cmd.temp;
		end
		rd_off_q <= off_mem[addr_q];
		rd_tmp_q <= tmp_mem[addr_q];
	end

	// Scan decisions
	assign gt       = (rd_off_q > elapsed_q);
	assign at_first = (addr_q == '0);
	assign at_last  = (CNT_W'(addr_q) == n_q - CNT_W'(1));

	// Segment fraction: (elapsed - lower) / (upper - lower)
	assign div_req.start = (state_q == S_CMP) && gt && !at_first;
	assign div_req.num   = elapsed_q - prev_off_q;
	assign div_req.den   = rd_off_q - prev_off_q;

	sipi_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Product of the temperature step and the fraction in two halves
	assign pp_lo_d  = diff_q * $signed({1'b0, frac_q[FRAC_LO_W-1:0]});
	assign pp_hi_d  = diff_q * $signed({1'b0, frac_q[FRACTION_BITS-1:FRAC_LO_W]});
	assign acc_d    = pp_lo_q + (pp_hi_q <<< FRAC_LO_W);
	assign interp_d = ACC_W'(prev_tmp_q) + (acc_q >>> FRACTION_BITS);

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				addr_q    <= '0;
				n_q       <= cmd.count;
				elapsed_q <= cmd.value;
			end
			S_CMP: begin
				if (gt) begin
					diff_q <= 33'(rd_tmp_q) - 33'(prev_tmp_q);
				end else if (at_last) begin
					res_q  <= rd_tmp_q;
					past_q <= 1'b1;
				end else begin
					prev_off_q <= rd_off_q;
					prev_tmp_q <= rd_tmp_q;
					addr_q     <= addr_q + 1'b1;
				end
			end
			S_DIV: begin
				frac_q <= div_rsp.quo;
			end
			S_MUL_LO: begin
				pp_lo_q <= pp_lo_d;
			end
			S_MUL_HI: begin
				pp_hi_q <= pp_hi_d;
			end
			S_ACC: begin
				acc_q <= acc_d;
			end
			S_FIN: begin
				res_q  <= interp_d[31:0];
				past_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd.is_eval) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (gt) begin
						state_q <= at_first ? S_IDLE : S_DIV;
					end else if (at_last) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_READ;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_ACC;
				S_ACC:    state_q <= S_FIN;
				S_FIN:    state_q <= S_OUT;
				S_OUT: begin
					if (!oq_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result queue
	assign oq_full = (oq_cnt_q == (AW + 1)'(OUTQ_DEPTH));
	assign oq_push = (state_q == S_OUT) && !oq_full;
	assign oq_pop  = pop && !empty;
	assign empty   = (oq_cnt_q == '0);
	assign result  = oq_mem[oq_rd_q];

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem[oq_wr_q] <= '{setpoint: res_q, past_end: past_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= (oq_wr_q == AW'(OUTQ_DEPTH - 1)) ? '0 : oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= (oq_rd_q == AW'(OUTQ_DEPTH - 1)) ? '0 : oq_rd_q + 1'b1;
			end
			case ({oq_push, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sipi_checker.sv =====
`default_nettype none

module sipi_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 push,
	input wire                 full,
	input wire                 empty,
	input wire                 pop,
	input sipi_pkg::out_item_t result
);
	import sipi_pkg::*;

	// Both queues come out of reset idle
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> (!full && empty))
		else $error("queues not idle after reset");

	// A waiting result holds while it is not taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

	// The input side fills only through an accepted transaction
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted transaction");

	// The result side drains only through a taken transaction
	a_empty_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop && !empty))
		else $error("empty rose without a taken transaction");

endmodule

bind setpoint_profile_interpolator_core sipi_checker u_chk (.*);

`default_nettype wire
